### sv/ttb_pkg.sv
// package for the triangle tangent basis core: widths, types and helpers
`timescale 1ns / 1ps
package ttb_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned DeltaW = 33;
  localparam int unsigned ProdW  = 66;
  localparam int unsigned SumW   = 67;
  // numerator magnitude after the q16 shift
  localparam int unsigned NumW   = 83;
  // quotient bits kept: anything above 32 only means saturation
  localparam int unsigned QuoW   = 34;
  localparam int unsigned FracShift = 16;
  localparam int unsigned NumComp = 6;
  localparam int unsigned CompIdxW = 3;
  // divider counts one quotient bit per cycle
  localparam int unsigned DivStepsW = 7;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_DIV_WAIT,
    ST_EMIT
  } ctrl_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic                store_v0;
    logic                store_v1;
    logic                start_tri;
    logic                mul_step;
    logic                div_start;
    logic [CompIdxW-1:0] comp_idx;
    logic                out_load;
    logic                out_last;
  } ttb_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic mul_done;
    logic det_zero;
    logic div_busy;
  } ttb_sts_t;

  // saturate signed quotient magnitude to int32
  function automatic logic [DataW-1:0] sat_q(input logic neg, input logic [QuoW-1:0] q);
    logic [QuoW-1:0] lim;
    logic [QuoW-1:0] negq;
    lim  = {{(QuoW-DataW){1'b0}}, 1'b1, {(DataW-1){1'b0}}};
    negq = ~q + {{(QuoW-1){1'b0}}, 1'b1};
    if (neg) begin
      if (q >= lim) sat_q = {1'b1, {(DataW-1){1'b0}}};
      else sat_q = negq[DataW-1:0];
    end else begin
      if (q >= lim) sat_q = {1'b0, {(DataW-1){1'b1}}};
      else sat_q = q[DataW-1:0];
    end
  endfunction

endpackage

### sv/ttb_div.sv
// restoring divider: one quotient bit per cycle, signed q16 with saturation
`timescale 1ns / 1ps
module ttb_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [ttb_pkg::SumW-1:0] num,
  input  logic signed [ttb_pkg::SumW-1:0] den,
  output logic                           busy,
  output logic                           done,
  output logic [ttb_pkg::DataW-1:0]      quo
);

  localparam int unsigned NW = ttb_pkg::NumW;
  localparam int unsigned DW = ttb_pkg::SumW;
  localparam int unsigned QW = ttb_pkg::QuoW;
  localparam int unsigned CW = ttb_pkg::DivStepsW;

  logic [NW-1:0] n_r, n_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW-1:0] num_mag, den_mag;
  logic [DW:0]   shifted, diff;

  assign num_mag = num[DW-1] ? (~num + 1'b1) : num;
  assign den_mag = den[DW-1] ? (~den + 1'b1) : den;
  assign shifted = {rem_r[DW-1:0], n_r[NW-1]};
  assign diff    = shifted - {1'b0, d_r};

  // load on start, iteration step while busy
  always_comb begin
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      n_nxt    = {num_mag, {ttb_pkg::FracShift{1'b0}}};
      rem_nxt  = '0;
      d_nxt    = den_mag;
      q_nxt    = '0;
      neg_nxt  = num[DW-1] ^ den[DW-1];
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt = {n_r[NW-2:0], 1'b0};
      if (!diff[DW]) begin
        rem_nxt = diff;
        // sticky top bit keeps saturation visible
        q_nxt = {q_r[QW-1] | q_r[QW-2], q_r[QW-3:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt = {q_r[QW-1] | q_r[QW-2], q_r[QW-3:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = ttb_pkg::sat_q(neg_r, q_r);

endmodule

### sv/ttb_datapath.sv
// datapath: held vertices, deltas, shared multiplier pair, divider, result register
`timescale 1ns / 1ps
module ttb_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ttb_pkg::ttb_cmd_t                cmd,
  output ttb_pkg::ttb_sts_t                sts,
  input  logic signed [ttb_pkg::DataW-1:0] in_pos_x,
  input  logic signed [ttb_pkg::DataW-1:0] in_pos_y,
  input  logic signed [ttb_pkg::DataW-1:0] in_pos_z,
  input  logic signed [ttb_pkg::DataW-1:0] in_tex_u,
  input  logic signed [ttb_pkg::DataW-1:0] in_tex_v,
  output logic signed [ttb_pkg::DataW-1:0] out_tangent_x,
  output logic signed [ttb_pkg::DataW-1:0] out_tangent_y,
  output logic signed [ttb_pkg::DataW-1:0] out_tangent_z,
  output logic signed [ttb_pkg::DataW-1:0] out_bitangent_x,
  output logic signed [ttb_pkg::DataW-1:0] out_bitangent_y,
  output logic signed [ttb_pkg::DataW-1:0] out_bitangent_z,
  output logic                             out_degenerate,
  output logic                             out_last_copy
);

  localparam int unsigned DW = ttb_pkg::DataW;
  localparam int unsigned EW = ttb_pkg::DeltaW;
  localparam int unsigned PW = ttb_pkg::ProdW;
  localparam int unsigned SW = ttb_pkg::SumW;
  localparam int unsigned NC = ttb_pkg::NumComp;

  // held vertex 0 and 1
  logic signed [DW-1:0] p0_r [3];
  logic signed [DW-1:0] p1_r [3];
  logic signed [DW-1:0] u0_r, v0_r, u1_r, v1_r;
  // deltas of the triangle
  logic signed [EW-1:0] dp1_r [3];
  logic signed [EW-1:0] dp2_r [3];
  logic signed [EW-1:0] du1_r, dv1_r, du2_r, dv2_r;
  // numerators 0..5 and determinant
  logic signed [SW-1:0] num_r [NC];
  logic signed [SW-1:0] det_r;
  logic signed [PW-1:0] pa_r, pb_r;
  logic [2:0]           mstep_r;
  logic                 msum_r;
  logic                 mul_done_r;
  logic [DW-1:0]        vec_r [NC];
  logic                 div_busy, div_done;
  logic [DW-1:0]        div_q;
  logic [ttb_pkg::CompIdxW-1:0] dcomp_r;
  logic signed [EW-1:0] ma, mb, mc, md;
  logic signed [SW-1:0] diffab;

  // operand select: step 0 det, 1..3 tangent, 4..6 bitangent
  always_comb begin
    ma = du1_r; mb = dv2_r; mc = dv1_r; md = du2_r;
    unique case (mstep_r)
      3'd1, 3'd2, 3'd3: begin
        ma = dp1_r[2'(mstep_r - 3'd1)]; mb = dv2_r;
        mc = dp2_r[2'(mstep_r - 3'd1)]; md = dv1_r;
      end
      3'd4, 3'd5, 3'd6: begin
        ma = dp2_r[2'(mstep_r - 3'd4)]; mb = du1_r;
        mc = dp1_r[2'(mstep_r - 3'd4)]; md = du2_r;
      end
      default: begin
        ma = du1_r; mb = dv2_r; mc = dv1_r; md = du2_r;
      end
    endcase
  end

  assign diffab = SW'(pa_r) - SW'(pb_r);

  // vertex store, deltas, product steps
  always_ff @(posedge clk) begin
    if (cmd.store_v0) begin
      p0_r[0] <= in_pos_x; p0_r[1] <= in_pos_y; p0_r[2] <= in_pos_z;
      u0_r <= in_tex_u; v0_r <= in_tex_v;
    end
    if (cmd.store_v1) begin
      p1_r[0] <= in_pos_x; p1_r[1] <= in_pos_y; p1_r[2] <= in_pos_z;
      u1_r <= in_tex_u; v1_r <= in_tex_v;
    end
    if (cmd.start_tri) begin
      dp1_r[0] <= EW'(p1_r[0]) - EW'(p0_r[0]);
      dp1_r[1] <= EW'(p1_r[1]) - EW'(p0_r[1]);
      dp1_r[2] <= EW'(p1_r[2]) - EW'(p0_r[2]);
      dp2_r[0] <= EW'(in_pos_x) - EW'(p0_r[0]);
      dp2_r[1] <= EW'(in_pos_y) - EW'(p0_r[1]);
      dp2_r[2] <= EW'(in_pos_z) - EW'(p0_r[2]);
      du1_r <= EW'(u1_r) - EW'(u0_r);
      dv1_r <= EW'(v1_r) - EW'(v0_r);
      du2_r <= EW'(in_tex_u) - EW'(u0_r);
      dv2_r <= EW'(in_tex_v) - EW'(v0_r);
    end
    if (cmd.mul_step) begin
      pa_r <= ma * mb;
      pb_r <= mc * md;
    end
    if (msum_r) begin
      if (mstep_r == 3'd1) det_r <= diffab;
      else num_r[mstep_r - 3'd2] <= diffab;
    end
  end

  // multiply sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mstep_r    <= '0;
      msum_r     <= 1'b0;
      mul_done_r <= 1'b0;
    end else begin
      msum_r     <= cmd.mul_step;
      mul_done_r <= 1'b0;
      if (cmd.start_tri) mstep_r <= '0;
      else if (cmd.mul_step) mstep_r <= mstep_r + 3'd1;
      if (msum_r && mstep_r == 3'd7) mul_done_r <= 1'b1;
    end
  end

  ttb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_r[cmd.comp_idx]),
    .den   (det_r),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_q)
  );

  // collect quotients
  always_ff @(posedge clk) begin
    if (cmd.div_start) dcomp_r <= cmd.comp_idx;
    if (div_done) vec_r[dcomp_r] <= div_q;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_degenerate <= (det_r == '0);
      out_last_copy  <= cmd.out_last;
      if (det_r == '0) begin
        out_tangent_x <= '0; out_tangent_y <= '0; out_tangent_z <= '0;
        out_bitangent_x <= '0; out_bitangent_y <= '0; out_bitangent_z <= '0;
      end else begin
        out_tangent_x   <= vec_r[0]; out_tangent_y   <= vec_r[1];
        out_tangent_z   <= vec_r[2]; out_bitangent_x <= vec_r[3];
        out_bitangent_y <= vec_r[4]; out_bitangent_z <= vec_r[5];
      end
    end
  end

  assign sts.mul_done = mul_done_r;
  assign sts.det_zero = (det_r == '0);
  assign sts.div_busy = div_busy | cmd.div_start | div_done;

endmodule

### sv/ttb_ctrl.sv
// controller: vertex phase, multiply and divide sequencing, result handshake
`timescale 1ns / 1ps
module ttb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  ttb_pkg::ttb_sts_t sts,
  output ttb_pkg::ttb_cmd_t cmd
);

  ttb_pkg::ctrl_state_t state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [2:0] mcnt_r, mcnt_nxt;
  logic [ttb_pkg::CompIdxW-1:0] comp_r, comp_nxt;
  logic [1:0] copy_r, copy_nxt;
  logic       ov_r, ov_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = ov_r && !out_stall;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    mcnt_nxt  = mcnt_r;
    comp_nxt  = comp_r;
    copy_nxt  = copy_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    in_stall  = 1'b1;
    if (out_acc) ov_nxt = 1'b0;
    unique case (state_r)
      ttb_pkg::ST_LOAD: begin
        in_stall = 1'b0;
        if (in_acc) begin
          cmd.store_v0  = (phase_r == 2'd0);
          cmd.store_v1  = (phase_r == 2'd1);
          cmd.start_tri = (phase_r == 2'd2);
          if (phase_r == 2'd2) begin
            phase_nxt = 2'd0;
            mcnt_nxt  = '0;
            state_nxt = ttb_pkg::ST_MUL;
          end else begin
            phase_nxt = phase_r + 2'd1;
          end
        end
      end
      ttb_pkg::ST_MUL: begin
        if (sts.mul_done) begin
          comp_nxt = '0;
          copy_nxt = '0;
          state_nxt = sts.det_zero ? ttb_pkg::ST_EMIT : ttb_pkg::ST_DIV;
        end else if (mcnt_r != 3'd7) begin
          cmd.mul_step = 1'b1;
          mcnt_nxt = mcnt_r + 3'd1;
        end
      end
      ttb_pkg::ST_DIV: begin
        cmd.div_start = 1'b1;
        cmd.comp_idx  = comp_r;
        state_nxt = ttb_pkg::ST_DIV_WAIT;
      end
      ttb_pkg::ST_DIV_WAIT: begin
        if (!sts.div_busy) begin
          if (comp_r == ttb_pkg::CompIdxW'(ttb_pkg::NumComp - 1)) begin
            state_nxt = ttb_pkg::ST_EMIT;
          end else begin
            comp_nxt = comp_r + 1'b1;
            state_nxt = ttb_pkg::ST_DIV;
          end
        end
      end
      ttb_pkg::ST_EMIT: begin
        if (!ov_r || out_acc) begin
          cmd.out_load = 1'b1;
          cmd.out_last = (copy_r == 2'd2);
          ov_nxt = 1'b1;
          copy_nxt = copy_r + 2'd1;
          if (copy_r == 2'd2) state_nxt = ttb_pkg::ST_LOAD;
        end
      end
      default: state_nxt = ttb_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ttb_pkg::ST_LOAD;
      phase_r <= '0;
      mcnt_r  <= '0;
      comp_r  <= '0;
      copy_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      mcnt_r  <= mcnt_nxt;
      comp_r  <= comp_nxt;
      copy_r  <= copy_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid = ov_r;

  // phase never reaches three
  a_phase: assert property (@(posedge clk) disable iff (!rst_n) phase_r != 2'd3)
    else $error("vertex phase out of range");
  // a request is taken only while loading
  a_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> state_r == ttb_pkg::ST_LOAD)
    else $error("request taken outside load");
  // third vertex starts the multiply sequence
  a_tri: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r == 2'd2) |=> state_r == ttb_pkg::ST_MUL)
    else $error("triangle not started");

endmodule

### sv/triangle_tangent_basis_core.sv
// top level of the triangle tangent basis core
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   pos_x/y/z, tex_u/v
//   out_     output     out_valid / out_stall tangent, bitangent, flags
// the first two vertices are stored as they are accepted; the third is accepted,
// then the multiply sequence runs and six divides follow on the shared serial divider,
// then three result copies are emitted; no new vertex is taken until the third copy is loaded
// a zero determinant skips the divider
// reset is synchronous, active low; held vertices are not cleared
// a stalled result holds back the next result until it is taken
`timescale 1ns / 1ps
module triangle_tangent_basis_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [ttb_pkg::DataW-1:0] in_pos_x,
  input  logic signed [ttb_pkg::DataW-1:0] in_pos_y,
  input  logic signed [ttb_pkg::DataW-1:0] in_pos_z,
  input  logic signed [ttb_pkg::DataW-1:0] in_tex_u,
  input  logic signed [ttb_pkg::DataW-1:0] in_tex_v,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [ttb_pkg::DataW-1:0] out_tangent_x,
  output logic signed [ttb_pkg::DataW-1:0] out_tangent_y,
  output logic signed [ttb_pkg::DataW-1:0] out_tangent_z,
  output logic signed [ttb_pkg::DataW-1:0] out_bitangent_x,
  output logic signed [ttb_pkg::DataW-1:0] out_bitangent_y,
  output logic signed [ttb_pkg::DataW-1:0] out_bitangent_z,
  output logic                             out_degenerate,
  output logic                             out_last_copy
);

  ttb_pkg::ttb_cmd_t cmd;
  ttb_pkg::ttb_sts_t sts;

  ttb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ttb_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_tex_u        (in_tex_u),
    .in_tex_v        (in_tex_v),
    .out_tangent_x   (out_tangent_x),
    .out_tangent_y   (out_tangent_y),
    .out_tangent_z   (out_tangent_z),
    .out_bitangent_x (out_bitangent_x),
    .out_bitangent_y (out_bitangent_y),
    .out_bitangent_z (out_bitangent_z),
    .out_degenerate  (out_degenerate),
    .out_last_copy   (out_last_copy)
  );

endmodule
